@@ design/clook_request_scheduler_assert.svh @@
// Assertion macros for the C-LOOK request scheduler.
// Used by the top level only; no other dependencies.
`ifndef CLOOK_REQUEST_SCHEDULER_ASSERT_SVH
`define CLOOK_REQUEST_SCHEDULER_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define CLK_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define CLK_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/clook_pkg.sv @@
// Shared types and constants for the C-LOOK request scheduler.
// No dependencies.
package clook_pkg;

    localparam int QUEUE_DEPTH = 32;
    localparam int SECTOR_BITS = 48;
    localparam int TAG_BITS    = 8;
    localparam int LEN_BITS    = 16;
    localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);
    localparam int IDX_BITS    = $clog2(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        MODE_ADD      = 2'd0,
        MODE_DISPATCH = 2'd1,
        MODE_REMOVE   = 2'd2,
        MODE_NONE     = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        EX_IDLE    = 2'd0,
        EX_EXECUTE = 2'd1,
        EX_REPORT  = 2'd2
    } exec_state_t;

    typedef struct packed {
        mode_t                  mode;
        logic [TAG_BITS-1:0]    tag;
        logic [SECTOR_BITS-1:0] sector;
        logic [LEN_BITS-1:0]    length;
    } cmd_t;

    typedef struct packed {
        status_t                status;
        logic                   grant_valid;
        logic [TAG_BITS-1:0]    grant_tag;
        logic [SECTOR_BITS-1:0] grant_sector;
        logic [LEN_BITS-1:0]    grant_length;
        logic [CNT_BITS-1:0]    pending_count;
        logic                   queue_empty;
    } result_t;

endpackage

@@ design/clook_cmd_fifo.sv @@
// Two-entry request queue between the front end and the sorted-cell engine.
// Depends on clook_pkg.
module clook_cmd_fifo
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  clook_pkg::cmd_t in_cmd,
    output logic            out_valid,
    input  logic            out_ready,
    output clook_pkg::cmd_t out_cmd
);

    clook_pkg::cmd_t slot_reg [2];
    logic            wr_ptr_reg;
    logic            rd_ptr_reg;
    logic [1:0]      fill_reg;
    logic            push;
    logic            pop;

    assign in_ready  = (fill_reg != 2'd2);
    assign out_valid = (fill_reg != 2'd0);
    assign out_cmd   = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            fill_reg <= fill_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

@@ design/clook_engine.sv @@
// Sorted cell array with C-LOOK dispatch; runs one request at a time.
// Depends on clook_pkg.
module clook_engine
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    input  clook_pkg::cmd_t    cmd,
    output logic               res_valid,
    input  logic               res_ready,
    output clook_pkg::result_t res
);

    localparam int QD = clook_pkg::QUEUE_DEPTH;
    localparam int SB = clook_pkg::SECTOR_BITS;
    localparam int TB = clook_pkg::TAG_BITS;
    localparam int LB = clook_pkg::LEN_BITS;
    localparam int CB = clook_pkg::CNT_BITS;
    localparam int IB = clook_pkg::IDX_BITS;

    logic [SB-1:0] sec_reg [QD];
    logic [LB-1:0] len_reg [QD];
    logic [TB-1:0] tag_reg [QD];
    logic [CB-1:0] count_reg;
    logic [CB-1:0] count_next;
    logic [SB:0]   head_reg;
    logic [SB:0]   head_next;

    clook_pkg::exec_state_t state_reg;
    clook_pkg::exec_state_t state_next;
    clook_pkg::cmd_t        cmd_reg;
    clook_pkg::result_t     res_reg;
    clook_pkg::result_t     res_next;

    logic [QD-1:0] live;
    logic [QD-1:0] le_vec;
    logic [QD-1:0] ge_vec;
    logic [QD-1:0] tag_vec;
    logic [QD-1:0] ins_vec;
    logic [QD-1:0] del_vec;
    logic [QD-1:0] first_ge;
    logic [QD-1:0] first_tag;
    logic [QD-1:0] pick;
    logic [QD-1:0] ins_one;
    logic [QD-1:0] shift_up;
    logic [QD-1:0] shift_dn;
    logic          do_add;
    logic          do_del;
    logic [IB-1:0] pick_idx;
    logic          latch_cmd;

    always_comb
    begin
        for (int i = 0; i < QD; i++)
        begin
            live[i]    = (CB'(i) < count_reg);
            le_vec[i]  = live[i] && (sec_reg[i] <= cmd_reg.sector);
            ge_vec[i]  = live[i] && ({1'b0, sec_reg[i]} >= head_reg);
            tag_vec[i] = live[i] && (tag_reg[i] == cmd_reg.tag);
        end
        first_ge  = ge_vec & ~(ge_vec - QD'(1));
        first_tag = tag_vec & ~(tag_vec - QD'(1));
        // insertion slot is first live entry above the new sector, or the tail
        ins_vec   = live & ~le_vec;
        ins_one   = (ins_vec != '0) ? (ins_vec & ~(ins_vec - QD'(1)))
                                    : (QD'(1) << count_reg[IB-1:0]);
        pick      = (cmd_reg.mode == clook_pkg::MODE_DISPATCH)
                  ? ((first_ge != '0) ? first_ge : QD'(1)) : first_tag;
        pick_idx  = '0;
        for (int i = 0; i < QD; i++)
        begin
            if (pick[i])
            begin
                pick_idx = IB'(i);
            end
        end
    end

    always_comb
    begin
        do_add   = 1'b0;
        do_del   = 1'b0;
        res_next = '0;
        head_next  = head_reg;
        count_next = count_reg;
        res_next.status = clook_pkg::ST_OK;
        unique case (cmd_reg.mode)
            clook_pkg::MODE_ADD:
            begin
                if (count_reg == CB'(QD))
                begin
                    res_next.status = clook_pkg::ST_FULL;
                end
                else
                begin
                    do_add     = 1'b1;
                    count_next = count_reg + CB'(1);
                end
            end
            clook_pkg::MODE_DISPATCH:
            begin
                if (count_reg == '0)
                begin
                    res_next.status = clook_pkg::ST_EMPTY;
                end
                else
                begin
                    do_del = 1'b1;
                    count_next = count_reg - CB'(1);
                    res_next.grant_valid  = 1'b1;
                    res_next.grant_tag    = tag_reg[pick_idx];
                    res_next.grant_sector = sec_reg[pick_idx];
                    res_next.grant_length = len_reg[pick_idx];
                    head_next = {1'b0, sec_reg[pick_idx]} + (SB+1)'(len_reg[pick_idx]);
                end
            end
            clook_pkg::MODE_REMOVE:
            begin
                if (first_tag == '0)
                begin
                    res_next.status = clook_pkg::ST_NOT_FOUND;
                end
                else
                begin
                    do_del = 1'b1;
                    count_next = count_reg - CB'(1);
                end
            end
            default:
            begin
                res_next.status = clook_pkg::ST_OK;
            end
        endcase
        res_next.pending_count = count_next;
        res_next.queue_empty   = (count_next == '0);
        shift_up = do_add ? ~(ins_one - QD'(1)) & ~ins_one : '0;
        del_vec  = do_del ? pick : '0;
        shift_dn = do_del ? ~((pick - QD'(1)) | pick) : '0;
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < QD; i++)
        begin
            if (do_add && (state_reg == clook_pkg::EX_EXECUTE))
            begin
                if (ins_one[i])
                begin
                    sec_reg[i] <= cmd_reg.sector;
                    len_reg[i] <= cmd_reg.length;
                    tag_reg[i] <= cmd_reg.tag;
                end
                else if (shift_up[i] && (i > 0))
                begin
                    sec_reg[i] <= sec_reg[(i > 0) ? i - 1 : 0];
                    len_reg[i] <= len_reg[(i > 0) ? i - 1 : 0];
                    tag_reg[i] <= tag_reg[(i > 0) ? i - 1 : 0];
                end
            end
            else if (do_del && (state_reg == clook_pkg::EX_EXECUTE))
            begin
                if ((del_vec[i] || shift_dn[i]) && (i < QD - 1))
                begin
                    sec_reg[i] <= sec_reg[(i < QD - 1) ? i + 1 : i];
                    len_reg[i] <= len_reg[(i < QD - 1) ? i + 1 : i];
                    tag_reg[i] <= tag_reg[(i < QD - 1) ? i + 1 : i];
                end
            end
        end
        if (latch_cmd)
        begin
            cmd_reg <= cmd;
        end
        if (state_reg == clook_pkg::EX_EXECUTE)
        begin
            res_reg <= res_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            clook_pkg::EX_IDLE:    if (cmd_valid) state_next = clook_pkg::EX_EXECUTE;
            clook_pkg::EX_EXECUTE: state_next = clook_pkg::EX_REPORT;
            clook_pkg::EX_REPORT:
            begin
                if (res_ready)
                begin
                    state_next = cmd_valid ? clook_pkg::EX_EXECUTE : clook_pkg::EX_IDLE;
                end
            end
            default:               state_next = clook_pkg::EX_IDLE;
        endcase
    end

    always_comb
    begin
        cmd_ready = (state_reg == clook_pkg::EX_IDLE)
                 || ((state_reg == clook_pkg::EX_REPORT) && res_ready);
        res_valid = (state_reg == clook_pkg::EX_REPORT);
        latch_cmd = cmd_valid && cmd_ready;
        res       = res_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= clook_pkg::EX_IDLE;
            count_reg <= '0;
            head_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == clook_pkg::EX_EXECUTE)
            begin
                count_reg <= count_next;
                head_reg  <= head_next;
            end
        end
    end

endmodule

@@ design/clook_request_scheduler.sv @@
// Top level of the C-LOOK request scheduler: stream ports, queue, engine.
// Depends on clook_pkg, clook_cmd_fifo, clook_engine and the assertion header.
`include "clook_request_scheduler_assert.svh"

// Each request in the sorted-cell engine is captured, then handled by one
// parallel compare-and-shift over all 32 cells; results leave through a
// register, and a two-entry queue in front accepts requests meanwhile while it has room.
module clook_request_scheduler
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [79:0]  s_tdata,   // mode[1:0], req_tag[9:2], start_sector[57:10], sector_count[73:58]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [87:0]  m_tdata    // status, grant_valid, grant_tag, grant_sector,
                                    // grant_length, pending_count, queue_empty
);

    clook_pkg::cmd_t    in_cmd;
    clook_pkg::cmd_t    q_cmd;
    clook_pkg::result_t res;
    logic               q_valid;
    logic               q_ready;

    assign in_cmd.mode   = clook_pkg::mode_t'(s_tdata[1:0]);
    assign in_cmd.tag    = s_tdata[9:2];
    assign in_cmd.sector = s_tdata[57:10];
    assign in_cmd.length = s_tdata[73:58];

    clook_cmd_fifo u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_cmd    (in_cmd),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_cmd   (q_cmd)
    );

    clook_engine u_engine
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (q_valid),
        .cmd_ready (q_ready),
        .cmd       (q_cmd),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res       (res)
    );

    assign m_tdata = {6'd0, res.queue_empty, res.pending_count, res.grant_length,
                      res.grant_sector, res.grant_tag, res.grant_valid, res.status};

    `CLK_ASSERT_IMP(a_empty_flag, m_tvalid, res.queue_empty == (res.pending_count == '0), "empty flag mismatch")
    `CLK_ASSERT_IMP(a_count_range, m_tvalid, res.pending_count <= 6'd32, "count out of range")
    `CLK_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result dropped")

endmodule
